@@ rtl/ftwg_pkg.sv @@
// Shared constants, codes and series helpers for the flat-top window generator.
`default_nettype none
package ftwg_pkg;

   localparam int DEF_MAX_LENGTH      = 4096;
   localparam int DEF_COS_TABLE_DEPTH = 1024;

   localparam int LEN_W  = 13;
   localparam int IDX_IN_W = 12;
   localparam int VAL_W  = 24;

   localparam logic [LEN_W-1:0] RESET_WINDOW_LENGTH = 13'd64;

   localparam logic [1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [1:0] CSR_NORM_MODE     = 2'd1;

   localparam logic [1:0] NORM_NONE = 2'd0;
   localparam logic [1:0] NORM_SUM  = 2'd1;
   localparam logic [1:0] NORM_L2   = 2'd2;
   localparam logic [1:0] NORM_PEAK = 2'd3;

   localparam logic [63:0] ONE_Q30     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic signed [31:0] A0 = 32'sd231476135;
   localparam logic signed [31:0] A1 = 32'sd447354753;
   localparam logic signed [31:0] A2 = 32'sd297709049;
   localparam logic signed [31:0] A3 = 32'sd89742211;
   localparam logic signed [31:0] A4 = 32'sd7459680;

   localparam logic [5:0] BASE_SHIFT = 6'd41;
   localparam logic [5:0] NONE_SHIFT = 6'd8;

   // harmonic weight with its alternating sign folded in
   function automatic logic signed [31:0] coef_signed(input logic [2:0] k);
      logic signed [31:0] c;
      case (k)
         3'd1:    c = -A1;
         3'd2:    c = A2;
         3'd3:    c = -A3;
         3'd4:    c = A4;
         default: c = 32'sd0;
      endcase
      return c;
   endfunction

   function automatic logic [63:0] sat_sub(input logic [63:0] sub);
      return (sub > ONE_Q30) ? 64'd0 : ONE_Q30 - sub;
   endfunction

   function automatic logic [63:0] series_cos(input logic [63:0] x2);
      logic [63:0] t;
      t = ONE_Q30;
      t = sat_sub(((x2 * t) >> 30) / 182);
      t = sat_sub(((x2 * t) >> 30) / 132);
      t = sat_sub(((x2 * t) >> 30) / 90);
      t = sat_sub(((x2 * t) >> 30) / 56);
      t = sat_sub(((x2 * t) >> 30) / 30);
      t = sat_sub(((x2 * t) >> 30) / 12);
      t = sat_sub(((x2 * t) >> 30) / 2);
      return t;
   endfunction

   function automatic logic [63:0] series_sin(input logic [63:0] x2);
      logic [63:0] t;
      t = ONE_Q30;
      t = sat_sub(((x2 * t) >> 30) / 210);
      t = sat_sub(((x2 * t) >> 30) / 156);
      t = sat_sub(((x2 * t) >> 30) / 110);
      t = sat_sub(((x2 * t) >> 30) / 72);
      t = sat_sub(((x2 * t) >> 30) / 42);
      t = sat_sub(((x2 * t) >> 30) / 20);
      t = sat_sub(((x2 * t) >> 30) / 6);
      return t;
   endfunction

endpackage
`default_nettype wire

@@ rtl/flat_top_window_generator_top.sv @@
// Flat-top window generator: cosine ROM, sample sequencer and normaliser.
//
//  channel | direction | beat payload
//  req_    | in        | tdata: sample_index
//  rsp_    | out       | tdata: sample_value ; tuser: index_error
//  csr_    | in        | csr_index, csr_data (write only)
//
// A sample takes one pass through the window sequencer (four cosine reads
// through the single registered ROM port), a multiply, a rounding stage and
// the output register. The first item after reset or a register write first
// recomputes the phase step and the normaliser: in mode none the phase step
// only, in the other modes two 64-step dividers and the normalising shifts,
// plus the square root in L2 mode and one sequencer pass per window sample
// for the sum and L2 modes.
// Reset is synchronous; a waiting result does not stall the acceptance of
// the next beat, only the delivery of the one after it.
`default_nettype none
module flat_top_window_generator_top #(
   parameter int MAX_LENGTH      = ftwg_pkg::DEF_MAX_LENGTH,
   parameter int COS_TABLE_DEPTH = ftwg_pkg::DEF_COS_TABLE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] sample_index
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [23:0] sample_value
   output logic             rsp_tuser,   // [0] index_error
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_data
);

   localparam int LEN_W = ftwg_pkg::LEN_W;
   localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PHDIV  = 4'd1;
   localparam logic [3:0] ST_SUM    = 4'd2;
   localparam logic [3:0] ST_ACC    = 4'd3;
   localparam logic [3:0] ST_SQRT   = 4'd4;
   localparam logic [3:0] ST_NINIT  = 4'd5;
   localparam logic [3:0] ST_NORM   = 4'd6;
   localparam logic [3:0] ST_RCDIV  = 4'd7;
   localparam logic [3:0] ST_SAMPLE = 4'd8;
   localparam logic [3:0] ST_RND    = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   localparam logic [3:0] WU_LAST = 4'd10;

   function automatic logic signed [31:0] cos_entry(input int unsigned k);
      logic [63:0] a, q, rem, x, x2, c, s;
      logic signed [31:0] r;
      a   = 64'(k) * 64'd4;
      q   = a / COS_TABLE_DEPTH;
      rem = a % COS_TABLE_DEPTH;
      x   = (rem * ftwg_pkg::HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / COS_TABLE_DEPTH;
      x2  = (x * x + (64'd1 << 29)) >> 30;
      c   = ftwg_pkg::series_cos(x2);
      s   = (x * ftwg_pkg::series_sin(x2)) >> 30;
      case (q[1:0])
         2'd0:    r = $signed(32'(c));
         2'd1:    r = -$signed(32'(s));
         2'd2:    r = -$signed(32'(c));
         default: r = $signed(32'(s));
      endcase
      return r;
   endfunction

   logic signed [31:0] cos_rom [COS_TABLE_DEPTH];
   for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
      assign cos_rom[g] = cos_entry(g);
   end

   // control
   logic [3:0]       state_ff, state_in;
   logic             ready_ff, ready_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] len_cfg_ff;
   logic [1:0]       mode_ff;

   // datapath
   logic [11:0]        item_n_ff;
   logic               err_ff;
   logic [31:0]        phase_step_ff, recip_ff;
   logic [5:0]         nshift_ff;
   logic               nneg_ff;
   logic [63:0]        dv_num_ff;
   logic [31:0]        dv_den_ff, dv_rem_ff;
   logic [6:0]         dv_cnt_ff;
   logic [LEN_W-1:0]   pass_n_ff;
   logic signed [47:0] nq_ff;
   logic [63:0]        sum_ff, sq_ff, sqv_ff, sqr_ff, sqbit_ff;
   logic [47:0]        mag_ff;
   logic signed [63:0] prod_ff;
   logic [5:0]         rshift_ff;
   logic               rneg_ff, rsign_ff;
   logic [63:0]        rmag_ff;
   logic [23:0]        rsp_data_ff;
   logic               rsp_err_ff;

   // window sequencer
   logic               wu_run_ff, wu_done_ff;
   logic [3:0]         wu_step_ff;
   logic [LEN_W-1:0]   wu_n_ff;
   logic [11:0]        wu_m_ff;
   logic               wu_center_ff;
   logic [31:0]        wu_mp_ff, wu_ph_ff;
   logic [IDX_W-1:0]   wu_addr_ff;
   logic signed [31:0] wu_cos_ff, wu_w_ff;
   logic signed [63:0] wu_prod_ff, wu_acc_ff;

   logic             wu_start;
   logic [LEN_W-1:0] wu_n_sel;

   logic [LEN_W-1:0] len_eff, wu_mirror, pass_next;
   logic             accept, slot_free, dv_take;
   logic [32:0]      dv_trial;
   logic [63:0]      wu_idx_prod, sq_sum, acc_sum, rd_abs, wu_acc_abs, wu_rnd;
   logic [31:0]      wu_idx_full, wu_abs;
   logic [IDX_W-1:0] wu_addr_sel;
   logic [2:0]       wu_k;
   logic [47:0]      nq_abs;
   logic [23:0]      sat_val;

   assign len_eff = (32'(len_cfg_ff) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH) : len_cfg_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

   assign dv_trial = {dv_rem_ff, dv_num_ff[63]};
   assign dv_take  = dv_trial >= {1'b0, dv_den_ff};

   assign pass_next = pass_n_ff + 1'b1;
   assign sq_sum    = sqr_ff + sqbit_ff;
   assign acc_sum   = sum_ff + sq_ff;
   assign nq_abs    = nq_ff[47] ? 48'(-nq_ff) : 48'(nq_ff);
   assign rd_abs    = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);

   assign wu_mirror   = len_eff - 1'b1 - wu_n_ff;
   assign wu_idx_prod = 64'(wu_ph_ff) * 64'(COS_TABLE_DEPTH) + 64'h8000_0000;
   assign wu_idx_full = wu_idx_prod[63:32];
   assign wu_addr_sel = (wu_idx_full >= 32'(COS_TABLE_DEPTH)) ? '0 : wu_idx_full[IDX_W-1:0];
   assign wu_k        = 3'(wu_step_ff - 4'd4);
   assign wu_acc_abs  = wu_acc_ff[63] ? 64'(-wu_acc_ff) : 64'(wu_acc_ff);
   assign wu_rnd      = (wu_acc_abs + (64'd1 << 29)) >> 30;
   assign wu_abs      = wu_w_ff[31] ? 32'(-wu_w_ff) : 32'(wu_w_ff);

   always_comb begin
      if (rsign_ff) begin
         sat_val = (rmag_ff > 64'd8388608) ? 24'h80_0000 : 24'(-rmag_ff);
      end else begin
         sat_val = (rmag_ff > 64'd8388607) ? 24'h7F_FFFF : 24'(rmag_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wu_start     = 1'b0;
      wu_n_sel     = LEN_W'(item_n_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wu_n_sel = LEN_W'(req_tdata[11:0]);
               if ({1'b0, req_tdata[11:0]} >= len_eff) begin
                  state_in = ST_OUT;
               end else if (!ready_ff) begin
                  state_in = ST_PHDIV;
               end else begin
                  wu_start = 1'b1;
                  state_in = ST_SAMPLE;
               end
            end
         end
         ST_PHDIV: begin
            if (dv_cnt_ff == '0) begin
               if (mode_ff == ftwg_pkg::NORM_NONE) begin
                  state_in = ST_NINIT;
               end else begin
                  wu_start = 1'b1;
                  wu_n_sel = (mode_ff == ftwg_pkg::NORM_PEAK) ? (len_eff >> 1) : '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (wu_done_ff) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (mode_ff != ftwg_pkg::NORM_PEAK && pass_next < len_eff) begin
               wu_start = 1'b1;
               wu_n_sel = pass_next;
               state_in = ST_SUM;
            end else if (mode_ff == ftwg_pkg::NORM_L2) begin
               state_in = ST_SQRT;
            end else begin
               state_in = ST_NINIT;
            end
         end
         ST_SQRT: begin
            if (sqbit_ff == '0) begin
               state_in = ST_NINIT;
            end
         end
         ST_NINIT: begin
            if (nq_ff == '0) begin
               ready_in = 1'b1;
               wu_start = 1'b1;
               state_in = ST_SAMPLE;
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (mag_ff[47:32] == '0 && mag_ff[31]) begin
               state_in = ST_RCDIV;
            end
         end
         ST_RCDIV: begin
            if (dv_cnt_ff == '0) begin
               ready_in = 1'b1;
               wu_start = 1'b1;
               state_in = ST_SAMPLE;
            end
         end
         ST_SAMPLE: begin
            if (wu_done_ff) begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid && csr_ready &&
          (csr_index == ftwg_pkg::CSR_WINDOW_LENGTH || csr_index == ftwg_pkg::CSR_NORM_MODE)) begin
         ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ready_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         len_cfg_ff    <= ftwg_pkg::RESET_WINDOW_LENGTH;
         mode_ff       <= ftwg_pkg::NORM_NONE;
         phase_step_ff <= '0;
         recip_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ftwg_pkg::CSR_WINDOW_LENGTH: len_cfg_ff <= csr_data;
               ftwg_pkg::CSR_NORM_MODE:     mode_ff    <= csr_data[1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_PHDIV && dv_cnt_ff == '0) begin
            phase_step_ff <= (len_eff > LEN_W'(1)) ? dv_num_ff[31:0] : '0;
         end
         if (state_ff == ST_NINIT && nq_ff == '0) begin
            recip_ff <= '0;
         end
         if (state_ff == ST_RCDIV && dv_cnt_ff == '0) begin
            recip_ff <= dv_num_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            item_n_ff <= req_tdata[11:0];
            err_ff    <= ({1'b0, req_tdata[11:0]} >= len_eff);
            dv_num_ff <= 64'h1_0000_0000;
            dv_den_ff <= 32'(len_eff - 1'b1);
            dv_rem_ff <= '0;
            dv_cnt_ff <= 7'd64;
            nq_ff     <= '0;
            sum_ff    <= '0;
            pass_n_ff <= '0;
         end
         ST_PHDIV, ST_RCDIV: begin
            if (dv_cnt_ff != '0) begin
               dv_rem_ff <= dv_take ? 32'(dv_trial - {1'b0, dv_den_ff}) : dv_trial[31:0];
               dv_num_ff <= {dv_num_ff[62:0], dv_take};
               dv_cnt_ff <= dv_cnt_ff - 1'b1;
            end
         end
         ST_SUM: begin
            sq_ff <= (64'(wu_abs) * 64'(wu_abs)) >> 10;
         end
         ST_ACC: begin
            pass_n_ff <= pass_next;
            sum_ff    <= acc_sum;
            if (mode_ff == ftwg_pkg::NORM_SUM) begin
               nq_ff <= nq_ff + $signed(48'(wu_abs));
            end else if (mode_ff == ftwg_pkg::NORM_PEAK) begin
               nq_ff <= 48'(wu_w_ff);
            end
            sqv_ff   <= acc_sum;
            sqr_ff   <= '0;
            sqbit_ff <= 64'd1 << 62;
         end
         ST_SQRT: begin
            if (sqbit_ff == '0) begin
               nq_ff <= $signed(48'(sqr_ff << 5));
            end else if (sqv_ff >= sq_sum) begin
               sqv_ff   <= sqv_ff - sq_sum;
               sqr_ff   <= (sqr_ff >> 1) + sqbit_ff;
               sqbit_ff <= sqbit_ff >> 2;
            end else begin
               sqr_ff   <= sqr_ff >> 1;
               sqbit_ff <= sqbit_ff >> 2;
            end
         end
         ST_NINIT: begin
            mag_ff    <= nq_abs;
            nshift_ff <= ftwg_pkg::BASE_SHIFT;
            nneg_ff   <= (nq_ff != '0) && nq_ff[47];
         end
         ST_NORM: begin
            if (mag_ff[47:32] != '0) begin
               mag_ff    <= mag_ff >> 1;
               nshift_ff <= nshift_ff + 1'b1;
            end else if (!mag_ff[31]) begin
               mag_ff    <= mag_ff << 1;
               nshift_ff <= nshift_ff - 1'b1;
            end else begin
               dv_num_ff <= 64'h7FFF_FFFF_FFFF_FFFF;
               dv_den_ff <= mag_ff[31:0];
               dv_rem_ff <= '0;
               dv_cnt_ff <= 7'd64;
            end
         end
         ST_SAMPLE: begin
            if (mode_ff == ftwg_pkg::NORM_NONE) begin
               prod_ff   <= 64'(wu_w_ff);
               rshift_ff <= ftwg_pkg::NONE_SHIFT;
               rneg_ff   <= 1'b0;
            end else begin
               prod_ff   <= $signed(64'(wu_w_ff)) * $signed(64'({1'b0, recip_ff}));
               rshift_ff <= nshift_ff;
               rneg_ff   <= nneg_ff;
            end
         end
         ST_RND: begin
            rmag_ff  <= (rd_abs + (64'd1 << (rshift_ff - 1'b1))) >> rshift_ff;
            rsign_ff <= prod_ff[63] ^ rneg_ff;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_data_ff <= err_ff ? '0 : sat_val;
               rsp_err_ff  <= err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wu_run_ff  <= 1'b0;
         wu_done_ff <= 1'b0;
         wu_step_ff <= '0;
      end else begin
         wu_done_ff <= wu_run_ff && (wu_step_ff == WU_LAST);
         if (wu_start) begin
            wu_run_ff  <= 1'b1;
            wu_step_ff <= '0;
         end else if (wu_run_ff) begin
            wu_step_ff <= wu_step_ff + 1'b1;
            if (wu_step_ff == WU_LAST) begin
               wu_run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wu_start) begin
         wu_n_ff <= wu_n_sel;
      end
      wu_addr_ff <= wu_addr_sel;
      wu_cos_ff  <= cos_rom[wu_addr_ff];
      wu_prod_ff <= ftwg_pkg::coef_signed(wu_k) * wu_cos_ff;
      if (wu_run_ff) begin
         if (wu_step_ff == 4'd0) begin
            wu_m_ff      <= 12'((wu_n_ff < wu_mirror) ? wu_n_ff : wu_mirror);
            wu_center_ff <= len_eff[0] && (wu_n_ff == ((len_eff - 1'b1) >> 1));
            wu_acc_ff    <= 64'(ftwg_pkg::A0) <<< 30;
            wu_ph_ff     <= '0;
         end
         if (wu_step_ff == 4'd1) begin
            wu_mp_ff <= 32'(44'(wu_m_ff) * 44'(phase_step_ff));
         end
         if (wu_step_ff >= 4'd2 && wu_step_ff <= 4'd5) begin
            wu_ph_ff <= wu_ph_ff + wu_mp_ff;
         end
         if (wu_step_ff >= 4'd6 && wu_step_ff <= 4'd9) begin
            wu_acc_ff <= wu_acc_ff + wu_prod_ff;
         end
         if (wu_step_ff == WU_LAST) begin
            if (wu_center_ff) begin
               wu_w_ff <= $signed(32'(ftwg_pkg::ONE_Q30));
            end else if (wu_acc_ff[63]) begin
               wu_w_ff <= -$signed(32'(wu_rnd));
            end else begin
               wu_w_ff <= $signed(32'(wu_rnd));
            end
         end
      end
   end

endmodule
`default_nettype wire
